@@ hw/rtl/pvc_pkg.sv @@
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types, codes and CP1251 letter mapping for the progressive Vigenere
// cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pvc_pkg;

    localparam int ALPHA = 33;
    localparam int LTR_W = 6;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_KEY     = 2'd1,
        OP_RESTART = 2'd2,
        OP_TEXT    = 2'd3
    } opcode_t;

    typedef struct packed {
        logic             hit;
        logic [LTR_W-1:0] idx;
    } letter_t;

    // Transaction travelling from the control stage to the mixing stage
    typedef struct packed {
        logic             valid;
        logic             pass;
        logic             no_key;
        logic [7:0]       data;
        logic [LTR_W-1:0] letter;
        logic [LTR_W-1:0] shift;
    } stage_t;

    // Map a CP1251 byte to its alphabet index, either case
    function automatic letter_t letter_index(input logic [7:0] b);
        letter_t    res;
        logic [7:0] u;
        begin
            res = '0;
            u   = (b >= 8'hE0) ? (b - 8'h20) : b;
            if (u == 8'hB8) begin
                u = 8'hA8;
            end
            if (u == 8'hA8) begin
                res.hit = 1'b1;
                res.idx = 6'd6;
            end else if (u >= 8'hC0 && u <= 8'hC5) begin
                res.hit = 1'b1;
                res.idx = LTR_W'(u - 8'hC0);
            end else if (u >= 8'hC6 && u <= 8'hDF) begin
                res.hit = 1'b1;
                res.idx = LTR_W'(u - 8'hBF);
            end
            return res;
        end
    endfunction

    // Map an alphabet index back to its upper-case CP1251 byte
    function automatic logic [7:0] letter_byte(input logic [LTR_W-1:0] idx);
        logic [7:0] res;
        begin
            if (idx < 6'd6) begin
                res = 8'hC0 + {2'b00, idx};
            end else if (idx == 6'd6) begin
                res = 8'hA8;
            end else begin
                res = 8'hBF + {2'b00, idx};
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pvc_key_mem.sv @@
// ----------------------------------------------------------------------------
// pvc_key_mem
// Key letter store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_key_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [ADDR_W-1:0]        wr_addr,
    input  wire logic [pvc_pkg::LTR_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [ADDR_W-1:0]        rd_addr,
    output logic      [pvc_pkg::LTR_W-1:0] rd_data
);

    logic [pvc_pkg::LTR_W-1:0] mem [DEPTH];
    logic [pvc_pkg::LTR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pvc_ctrl
// Command decode, key length / position / round shift tracking and key store
// addressing. Issues the key read for each text letter.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_ctrl #(
    parameter int MAX_KEY = 16,
    parameter int IDX_W   = 4,
    parameter int LEN_W   = 5
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic                      advance,
    input  wire logic [1:0]                opcode,
    input  wire logic [7:0]                in_byte,
    output logic                           wr_en,
    output logic      [IDX_W-1:0]          wr_addr,
    output logic      [pvc_pkg::LTR_W-1:0] wr_data,
    output logic                           rd_en,
    output logic      [IDX_W-1:0]          rd_addr,
    output pvc_pkg::stage_t                stage
);

    logic [LEN_W-1:0]          len_reg,   len_next;
    logic [IDX_W-1:0]          pos_reg,   pos_next;
    logic [pvc_pkg::LTR_W-1:0] shift_reg, shift_next;
    pvc_pkg::stage_t           stage_reg, stage_next;

    pvc_pkg::letter_t          ltr;
    pvc_pkg::opcode_t          op;
    logic [IDX_W-1:0]          pos_eff;
    logic [LEN_W-1:0]          pos_inc;

    assign ltr     = pvc_pkg::letter_index(in_byte);
    assign op      = pvc_pkg::opcode_t'(opcode);
    assign pos_eff = (LEN_W'(pos_reg) < len_reg) ? pos_reg : '0;
    assign pos_inc = LEN_W'(pos_eff) + LEN_W'(1);

    always_comb
    begin
        len_next   = len_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        wr_en      = 1'b0;
        wr_addr    = len_reg[IDX_W-1:0];
        wr_data    = ltr.idx;
        rd_en      = 1'b0;
        rd_addr    = pos_eff;

        stage_next        = stage_reg;
        if (advance)
        begin
            stage_next.valid = 1'b0;
        end

        if (accept)
        begin
            stage_next.valid  = (op == pvc_pkg::OP_TEXT);
            stage_next.no_key = (len_reg == '0);
            stage_next.pass   = (len_reg == '0) || !ltr.hit;
            stage_next.data   = in_byte;
            stage_next.letter = ltr.idx;
            stage_next.shift  = shift_reg;

            unique case (op)
                pvc_pkg::OP_CLEAR:
                begin
                    len_next   = '0;
                    pos_next   = '0;
                    shift_next = '0;
                end
                pvc_pkg::OP_KEY:
                begin
                    if (ltr.hit && len_reg < LEN_W'(MAX_KEY))
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                pvc_pkg::OP_RESTART:
                begin
                    pos_next   = '0;
                    shift_next = '0;
                end
                pvc_pkg::OP_TEXT:
                begin
                    if (len_reg != '0 && ltr.hit)
                    begin
                        rd_en = 1'b1;
                        // Wrap to the first key letter and bump the round shift
                        if (pos_inc >= len_reg)
                        begin
                            pos_next   = '0;
                            shift_next = (shift_reg == pvc_pkg::LTR_W'(pvc_pkg::ALPHA - 1))
                                       ? '0 : shift_reg + pvc_pkg::LTR_W'(1);
                        end
                        else
                        begin
                            pos_next = pos_inc[IDX_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            pos_reg   <= '0;
            shift_reg <= '0;
            stage_reg <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pvc_mix.sv @@
// ----------------------------------------------------------------------------
// pvc_mix
// Combines the key letter read from the store with the round shift, applies
// the letter shift and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_mix (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire logic                      decrypt_mode,
    input  wire pvc_pkg::stage_t           stage,
    input  wire logic [pvc_pkg::LTR_W-1:0] key_letter,
    output logic                           out_valid,
    output logic      [7:0]                out_byte,
    output logic                           no_key
);

    localparam logic [pvc_pkg::LTR_W:0] ALPHA_W = (pvc_pkg::LTR_W + 1)'(pvc_pkg::ALPHA);

    logic                        valid_reg;
    logic [7:0]                  byte_reg,   byte_next;
    logic                        no_key_reg;
    logic [pvc_pkg::LTR_W:0]     key_sum;
    logic [pvc_pkg::LTR_W-1:0]   key_mod;
    logic [pvc_pkg::LTR_W:0]     mix_sum;
    logic [pvc_pkg::LTR_W-1:0]   mix_mod;

    always_comb
    begin
        key_sum = {1'b0, key_letter} + {1'b0, stage.shift};
        key_mod = (key_sum >= ALPHA_W) ? pvc_pkg::LTR_W'(key_sum - ALPHA_W)
                                       : key_sum[pvc_pkg::LTR_W-1:0];
        if (decrypt_mode)
        begin
            mix_sum = {1'b0, stage.letter} + ALPHA_W - {1'b0, key_mod};
        end
        else
        begin
            mix_sum = {1'b0, stage.letter} + {1'b0, key_mod};
        end
        mix_mod = (mix_sum >= ALPHA_W) ? pvc_pkg::LTR_W'(mix_sum - ALPHA_W)
                                       : mix_sum[pvc_pkg::LTR_W-1:0];
        byte_next = stage.pass ? stage.data : pvc_pkg::letter_byte(mix_mod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg   <= byte_next;
            no_key_reg <= stage.no_key;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign no_key    = no_key_reg;

endmodule

`default_nettype wire

@@ hw/rtl/progressive_vigenere_cp1251_unit.sv @@
// ----------------------------------------------------------------------------
// progressive_vigenere_cp1251_unit
// Progressive-key Vigenere cipher over the 33-letter Russian alphabet on a
// CP1251 byte stream.
//
//   channel   dir   payload                         handshake
//   s_*       in    tuser opcode, tdata byte        tvalid/tready
//   m_*       out   tdata byte, tuser no_key        tvalid/tready
//   cfg_*     in    data decrypt_mode               valid/ready
//
// One transaction per cycle while m_tready does not stall; a text byte taken on s_*
// is registered first by the key store read and then by the output register.
// All stages advance together whenever the output register is free or being
// drained, so a stall on m_tready holds s_tready low.
// Reset clears the key length, position and round shift; the key store needs
// no clearing since only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module progressive_vigenere_cp1251_unit #(
    parameter int MAX_KEY = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic [1:0] s_tuser,   // [1:0] opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] out_byte
    output logic      [0:0] m_tuser,   // [0] no_key
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [0:0] cfg_data   // [0] decrypt_mode
);

    localparam int IDX_W = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int LEN_W = $clog2(MAX_KEY + 1);

    logic                      mode_reg;
    logic                      advance;
    logic                      accept;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [pvc_pkg::LTR_W-1:0] wr_data;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic [pvc_pkg::LTR_W-1:0] rd_data;
    pvc_pkg::stage_t           stage;

    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data[0];
        end
    end

    pvc_ctrl #(
        .MAX_KEY (MAX_KEY),
        .IDX_W   (IDX_W),
        .LEN_W   (LEN_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .advance (advance),
        .opcode  (s_tuser),
        .in_byte (s_tdata),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .stage   (stage)
    );

    pvc_key_mem #(
        .DEPTH  (MAX_KEY),
        .ADDR_W (IDX_W)
    ) u_key_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pvc_mix u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .decrypt_mode (mode_reg),
        .stage        (stage),
        .key_letter   (rd_data),
        .out_valid    (m_tvalid),
        .out_byte     (m_tdata),
        .no_key       (m_tuser[0])
    );

endmodule

`default_nettype wire

@@ sim/tb_progressive_vigenere_cp1251_unit.sv @@
// ----------------------------------------------------------------------------
// tb_progressive_vigenere_cp1251_unit
// Self-checking bench for the progressive-key Vigenere cipher unit. A directed
// sequence covers the empty key, dropped key bytes, case folding, the YO
// letter, a key byte joining mid-message and restart. It is followed by random
// phases of clear/key/restart/text messages with some noise mixed in, in both
// cipher directions. Both stream sides idle at random. A scoreboard predicts
// every text byte and compares the results in order.
// ----------------------------------------------------------------------------

module tb_progressive_vigenere_cp1251_unit;

    localparam int KEY_DEPTH    = 16;
    localparam int PIPE_SETTLE  = 6;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 70;
    localparam int MAX_GAP      = 18;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       no_key;
    } cipher_out_t;

    // ------------------------------------------------------------------------
    // Scoreboard with its own copy of the cipher state
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        logic [pvc_pkg::LTR_W-1:0] key_alpha [KEY_DEPTH];
        int                        key_len;
        int                        key_pos;
        int                        round_shift;
        bit                        decrypt;
        cipher_out_t               expected_q [$];
        int                        errors;

        function new();
            key_len     = 0;
            key_pos     = 0;
            round_shift = 0;
            decrypt     = 1'b0;
            errors      = 0;
        endfunction

        // Alphabet position of a CP1251 byte, -1 for anything else
        function int letter_code(logic [7:0] b);
            if (b == 8'hA8 || b == 8'hB8) begin
                return 6;
            end
            if (b[7:6] != 2'b11) begin
                return -1;
            end
            return (b[4:0] < 5'd6) ? int'(b[4:0]) : int'(b[4:0]) + 1;
        endfunction

        function logic [7:0] capital_of(int code);
            if (code == 6) begin
                return 8'hA8;
            end
            return 8'hC0 + 8'((code < 6) ? code : code - 1);
        endfunction

        function void set_mode(bit m);
            decrypt = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Queue one predicted result at the tail
        function void add_expected(logic [7:0] b, logic f);
            cipher_out_t entry;
            entry.out_byte = b;
            entry.no_key   = f;
            expected_q.insert(expected_q.size(), entry);
        endfunction

        function void note_transaction(pvc_pkg::opcode_t op, logic [7:0] b);
            int code;
            int k;
            int r;
            code = letter_code(b);
            case (op)
                pvc_pkg::OP_CLEAR: begin
                    key_len     = 0;
                    key_pos     = 0;
                    round_shift = 0;
                end
                pvc_pkg::OP_KEY: begin
                    if (code >= 0 && key_len < KEY_DEPTH) begin
                        key_alpha[key_len] = pvc_pkg::LTR_W'(code);
                        key_len++;
                    end
                end
                pvc_pkg::OP_RESTART: begin
                    key_pos     = 0;
                    round_shift = 0;
                end
                default: begin
                    if (key_len == 0) begin
                        add_expected(b, 1'b1);
                    end else if (code < 0) begin
                        add_expected(b, 1'b0);
                    end else begin
                        if (key_pos >= key_len) begin
                            key_pos = 0;
                        end
                        k = (int'(key_alpha[key_pos]) + round_shift) % pvc_pkg::ALPHA;
                        r = decrypt ? (code + pvc_pkg::ALPHA - k) % pvc_pkg::ALPHA
                                    : (code + k) % pvc_pkg::ALPHA;
                        add_expected(capital_of(r), 1'b0);
                        // advance through the key; a full lap bumps the shift
                        key_pos++;
                        if (key_pos >= key_len) begin
                            key_pos     = 0;
                            round_shift = (round_shift + 1) % pvc_pkg::ALPHA;
                        end
                    end
                end
            endcase
        endfunction

        function void check_transaction(logic [7:0] got_byte, logic got_flag);
            cipher_out_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result out_byte=%h no_key=%b",
                         $time, got_byte, got_flag);
                return;
            end
            want = expected_q.pop_front();
            if (got_byte !== want.out_byte) begin
                errors++;
                $display("%0t: out_byte mismatch expected=%h actual=%h",
                         $time, want.out_byte, got_byte);
            end
            if (got_flag !== want.no_key) begin
                errors++;
                $display("%0t: no_key mismatch expected=%b actual=%b",
                         $time, want.no_key, got_flag);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and signals
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_data;

    cipher_scoreboard sb;
    int               items_sent;
    int               cycle_count;
    bit               src_steady;
    bit               snk_steady;

    progressive_vigenere_cp1251_unit #(
        .MAX_KEY (KEY_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] in_byte
        .s_tuser   (s_tuser),    // [1:0] opcode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] out_byte
        .m_tuser   (m_tuser),    // [0] no_key
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)    // [0] decrypt_mode
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks; each starts and ends right after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_item(pvc_pkg::opcode_t op, logic [7:0] b);
        int gap;
        begin
            if ($urandom_range(0, 39) == 0) begin
                src_steady = !src_steady;
            end
            gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= b;
            do @(posedge clk); while (!s_tready);
            sb.note_transaction(op, b);
            items_sent++;
        end
    endtask

    // Hold off until every expected result is back and the pipe has drained
    task automatic wait_idle();
        begin
            s_tvalid <= 1'b0;
            while (sb.pending() > 0) @(posedge clk);
            repeat (PIPE_SETTLE) @(posedge clk);
        end
    endtask

    task automatic write_mode(bit m);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= m;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            sb.set_mode(m);
        end
    endtask

    function automatic logic [7:0] any_letter();
        int r;
        r = $urandom_range(0, 65);
        if (r == 64) begin
            return 8'hA8;
        end
        if (r == 65) begin
            return 8'hB8;
        end
        return 8'hC0 + 8'(r);
    endfunction

    // One message: optional clear, key bytes, optional restart, text; or noise
    task automatic send_message();
        int n_key;
        int n_text;
        begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(pvc_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom));
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    send_item(pvc_pkg::OP_CLEAR, 8'($urandom));
                end
                n_key = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 20)
                                                   : $urandom_range(0, 5);
                repeat (n_key) begin
                    send_item(pvc_pkg::OP_KEY, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                          : any_letter());
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_item(pvc_pkg::OP_RESTART, 8'($urandom));
                end
                n_text = $urandom_range(1, 40);
                repeat (n_text) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_item(pvc_pkg::OP_KEY, any_letter());
                    end
                    send_item(pvc_pkg::OP_TEXT, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                           : any_letter());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, check every transaction
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                snk_steady = !snk_steady;
            end
            stall = snk_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_transaction(m_tdata, m_tuser[0]);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        sb         = new();
        items_sent = 0;
        src_steady = 1'b0;
        snk_steady = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= pvc_pkg::OP_CLEAR;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);

        // empty key: text passes flagged, non-letter key bytes are dropped
        send_item(pvc_pkg::OP_TEXT,    8'hC0);
        send_item(pvc_pkg::OP_TEXT,    8'h00);
        send_item(pvc_pkg::OP_KEY,     8'h20);
        send_item(pvc_pkg::OP_TEXT,    8'hFF);
        // key YO, lower-case ya, A
        send_item(pvc_pkg::OP_KEY,     8'hA8);
        send_item(pvc_pkg::OP_KEY,     8'hFF);
        send_item(pvc_pkg::OP_KEY,     8'h7F);
        send_item(pvc_pkg::OP_KEY,     8'hC0);
        send_item(pvc_pkg::OP_TEXT,    8'hB8);
        send_item(pvc_pkg::OP_TEXT,    8'hE0);
        send_item(pvc_pkg::OP_TEXT,    8'h2E);
        send_item(pvc_pkg::OP_TEXT,    8'hDF);
        send_item(pvc_pkg::OP_TEXT,    8'hC5);
        // key letter joins mid-message
        send_item(pvc_pkg::OP_KEY,     8'hC6);
        send_item(pvc_pkg::OP_TEXT,    8'hC6);
        send_item(pvc_pkg::OP_TEXT,    8'hE6);
        send_item(pvc_pkg::OP_RESTART, 8'hFF);
        send_item(pvc_pkg::OP_TEXT,    8'hA8);
        send_item(pvc_pkg::OP_CLEAR,   8'h55);
        send_item(pvc_pkg::OP_TEXT,    8'h41);
        send_item(pvc_pkg::OP_KEY,     8'hB8);
        send_item(pvc_pkg::OP_TEXT,    8'hFF);
        send_item(pvc_pkg::OP_TEXT,    8'hFF);
        send_item(pvc_pkg::OP_TEXT,    8'h80);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            write_mode((phase == 0) ? 1'b1 : (phase == 1) ? 1'b0
                                           : 1'($urandom_range(0, 1)));
            while (items_sent < 24 + (phase + 1) * PHASE_ITEMS) begin
                send_message();
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
